### sv/rmmc_pkg.sv
// Shared types, codes and constants for the robot mission mode controller.
package rmmc_pkg;

    localparam int unsigned MAX_WAYPOINTS_DEF = 16;
    localparam int unsigned WP_IDX_W = 4;
    localparam int unsigned WP_CNT_W = 5;
    localparam int unsigned LEVEL_W = 10;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [LEVEL_W-1:0] BATT_LOW_RST = 10'd200;
    localparam logic [LEVEL_W-1:0] BATT_FULL_RST = 10'd950;
    localparam logic [WP_CNT_W-1:0] PATROL_CNT_RST = 5'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BATT_LOW = 2'd0,
        REG_BATT_FULL = 2'd1,
        REG_PATROL_CNT = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MODE_STANDBY = 3'd0,
        MODE_PATROL = 3'd1,
        MODE_SERVICE = 3'd2,
        MODE_PAUSED = 3'd3,
        MODE_RESTING = 3'd4,
        MODE_CHARGING = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        CMD_ACTIVATE = 3'd0,
        CMD_PAUSE = 3'd1,
        CMD_RESUME = 3'd2,
        CMD_SERVICE_REQ = 3'd3,
        CMD_BATTERY = 3'd4,
        CMD_NAV_IDLE = 3'd5,
        CMD_TICK = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        SPEED_KEEP = 2'd0,
        SPEED_PATROL = 2'd1,
        SPEED_SERVICE = 2'd2
    } speed_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_QUEUE = 2'd1,
        ACT_PREEMPT = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        SRC_PATROL = 2'd0,
        SRC_SERVICE = 2'd1,
        SRC_DOCK = 2'd2
    } source_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] battery_low_level;
        logic [LEVEL_W-1:0] battery_full_level;
        logic [WP_CNT_W-1:0] patrol_point_count;
    } cfg_t;

    typedef struct packed {
        cmd_t cmd;
        logic [7:0] req_priority;
        logic signed [31:0] req_x;
        logic signed [31:0] req_y;
        logic [15:0] req_heading;
        logic [15:0] req_dwell_ticks;
        logic req_back_to_patrol;
        logic req_halt_first;
        logic [LEVEL_W-1:0] battery_level;
    } item_t;

    typedef struct packed {
        mode_t mode;
        speed_t speed_set;
        action_t goal_action;
        source_t goal_source;
        logic [WP_IDX_W-1:0] goal_waypoint;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic [15:0] goal_heading;
        logic cancel_nav;
    } result_t;

endpackage

### sv/rmmc_event_if.sv
// Channel interface that carries one event beat into the controller.
interface rmmc_event_if;
    logic valid;
    logic ready;
    logic [2:0] cmd;
    logic [7:0] req_priority;
    logic signed [31:0] req_x;
    logic signed [31:0] req_y;
    logic [15:0] req_heading;
    logic [15:0] req_dwell_ticks;
    logic req_back_to_patrol;
    logic req_halt_first;
    logic [9:0] battery_level;

    modport source (
        output valid, cmd, req_priority, req_x, req_y, req_heading,
        output req_dwell_ticks, req_back_to_patrol, req_halt_first, battery_level,
        input ready
    );

    modport sink (
        input valid, cmd, req_priority, req_x, req_y, req_heading,
        input req_dwell_ticks, req_back_to_patrol, req_halt_first, battery_level,
        output ready
    );
endinterface

### sv/rmmc_result_if.sv
// Channel interface that carries one result beat out of the controller.
interface rmmc_result_if;
    logic valid;
    logic ready;
    logic [2:0] mode;
    logic [1:0] speed_set;
    logic [1:0] goal_action;
    logic [1:0] goal_source;
    logic [3:0] goal_waypoint;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic [15:0] goal_heading;
    logic cancel_nav;

    modport source (
        output valid, mode, speed_set, goal_action, goal_source, goal_waypoint,
        output goal_x, goal_y, goal_heading, cancel_nav,
        input ready
    );

    modport sink (
        input valid, mode, speed_set, goal_action, goal_source, goal_waypoint,
        input goal_x, goal_y, goal_heading, cancel_nav,
        output ready
    );
endinterface

### sv/rmmc_core.sv
// Mission state registers and the combinational event decode that updates them.
module rmmc_core #(
    parameter int unsigned MaxWaypoints = rmmc_pkg::MAX_WAYPOINTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  rmmc_pkg::cfg_t   cfg,
    input  rmmc_pkg::item_t  item,
    output rmmc_pkg::result_t result
);
    import rmmc_pkg::*;

    localparam int unsigned CapWp = (MaxWaypoints < 16) ? MaxWaypoints : 16;
    localparam logic [WP_CNT_W-1:0] WpCap = WP_CNT_W'(CapWp);

    mode_t               mode_reg, mode_next;
    mode_t               pause_mode_reg, pause_mode_next;
    logic                rest_deferred_reg, rest_deferred_next;
    logic                halt_waiting_reg, halt_waiting_next;
    logic [WP_IDX_W-1:0] patrol_idx_reg, patrol_idx_next;
    logic [7:0]          active_prio_reg, active_prio_next;
    logic signed [31:0]  svc_x_reg, svc_x_next;
    logic signed [31:0]  svc_y_reg, svc_y_next;
    logic [15:0]         svc_heading_reg, svc_heading_next;
    logic [15:0]         svc_dwell_reg, svc_dwell_next;
    logic                svc_back_reg, svc_back_next;
    logic [15:0]         dwell_left_reg, dwell_left_next;
    logic                dwell_run_reg, dwell_run_next;

    logic [WP_CNT_W-1:0] points;
    logic [WP_CNT_W-1:0] idx_inc;
    logic                serving;
    logic                want_patrol;
    speed_t              speed;
    action_t             action;
    source_t             source;
    logic                cancel;
    logic [15:0]         dwell_dec;

    assign points = (cfg.patrol_point_count > WpCap) ? WpCap : cfg.patrol_point_count;
    assign idx_inc = {1'b0, patrol_idx_reg} + WP_CNT_W'(1);
    assign serving = (mode_reg == MODE_SERVICE) ||
                     ((mode_reg == MODE_PAUSED) && (pause_mode_reg == MODE_SERVICE));
    assign dwell_dec = (dwell_left_reg != 16'd0) ? (dwell_left_reg - 16'd1) : 16'd0;

    always_comb
    begin
        mode_next = mode_reg;
        pause_mode_next = pause_mode_reg;
        rest_deferred_next = rest_deferred_reg;
        halt_waiting_next = halt_waiting_reg;
        patrol_idx_next = patrol_idx_reg;
        active_prio_next = active_prio_reg;
        svc_x_next = svc_x_reg;
        svc_y_next = svc_y_reg;
        svc_heading_next = svc_heading_reg;
        svc_dwell_next = svc_dwell_reg;
        svc_back_next = svc_back_reg;
        dwell_left_next = dwell_left_reg;
        dwell_run_next = dwell_run_reg;
        want_patrol = 1'b0;
        speed = SPEED_KEEP;
        action = ACT_NONE;
        source = SRC_PATROL;
        cancel = 1'b0;

        case (item.cmd)
            CMD_ACTIVATE:
            begin
                if (mode_reg == MODE_STANDBY)
                begin
                    patrol_idx_next = '0;
                    mode_next = MODE_PATROL;
                    rest_deferred_next = 1'b0;
                    speed = SPEED_PATROL;
                    want_patrol = 1'b1;
                end
            end
            CMD_PAUSE:
            begin
                if (mode_reg == MODE_PATROL || mode_reg == MODE_SERVICE ||
                    mode_reg == MODE_RESTING)
                begin
                    pause_mode_next = mode_reg;
                    mode_next = MODE_PAUSED;
                    dwell_run_next = 1'b0;
                    dwell_left_next = '0;
                    cancel = 1'b1;
                end
            end
            CMD_RESUME:
            begin
                if (mode_reg == MODE_PAUSED)
                begin
                    case (pause_mode_reg)
                        MODE_PATROL:
                        begin
                            mode_next = MODE_PATROL;
                            speed = SPEED_PATROL;
                            want_patrol = 1'b1;
                        end
                        MODE_SERVICE:
                        begin
                            mode_next = MODE_SERVICE;
                            speed = SPEED_SERVICE;
                            action = ACT_QUEUE;
                            source = SRC_SERVICE;
                        end
                        MODE_RESTING:
                        begin
                            mode_next = MODE_RESTING;
                            speed = SPEED_SERVICE;
                            action = ACT_QUEUE;
                            source = SRC_DOCK;
                        end
                        default:
                        begin
                            patrol_idx_next = '0;
                            mode_next = MODE_PATROL;
                            rest_deferred_next = 1'b0;
                            speed = SPEED_PATROL;
                            want_patrol = 1'b1;
                        end
                    endcase
                end
            end
            CMD_SERVICE_REQ:
            begin
                if (mode_reg != MODE_STANDBY && mode_reg != MODE_RESTING &&
                    mode_reg != MODE_CHARGING &&
                    !(serving && item.req_priority <= active_prio_reg))
                begin
                    dwell_run_next = 1'b0;
                    dwell_left_next = '0;
                    active_prio_next = item.req_priority;
                    svc_x_next = item.req_x;
                    svc_y_next = item.req_y;
                    svc_heading_next = item.req_heading;
                    svc_dwell_next = item.req_dwell_ticks;
                    svc_back_next = item.req_back_to_patrol;
                    if (item.req_halt_first)
                    begin
                        halt_waiting_next = 1'b1;
                        cancel = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_SERVICE;
                        rest_deferred_next = 1'b0;
                        speed = SPEED_SERVICE;
                        action = ACT_PREEMPT;
                        source = SRC_SERVICE;
                    end
                end
            end
            CMD_BATTERY:
            begin
                if (item.battery_level <= cfg.battery_low_level &&
                    mode_reg != MODE_STANDBY && mode_reg != MODE_RESTING &&
                    mode_reg != MODE_CHARGING)
                begin
                    if (serving)
                    begin
                        rest_deferred_next = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_RESTING;
                        rest_deferred_next = 1'b0;
                        dwell_run_next = 1'b0;
                        dwell_left_next = '0;
                        speed = SPEED_SERVICE;
                        action = ACT_QUEUE;
                        source = SRC_DOCK;
                    end
                end
                else if (item.battery_level >= cfg.battery_full_level &&
                         mode_reg == MODE_CHARGING)
                begin
                    patrol_idx_next = '0;
                    mode_next = MODE_PATROL;
                    rest_deferred_next = 1'b0;
                    speed = SPEED_PATROL;
                    want_patrol = 1'b1;
                end
            end
            CMD_NAV_IDLE:
            begin
                if (halt_waiting_reg)
                begin
                    halt_waiting_next = 1'b0;
                    mode_next = MODE_SERVICE;
                    rest_deferred_next = 1'b0;
                    speed = SPEED_SERVICE;
                    action = ACT_PREEMPT;
                    source = SRC_SERVICE;
                end
                else if (rest_deferred_reg)
                begin
                    mode_next = MODE_RESTING;
                    rest_deferred_next = 1'b0;
                    dwell_run_next = 1'b0;
                    dwell_left_next = '0;
                    speed = SPEED_SERVICE;
                    action = ACT_QUEUE;
                    source = SRC_DOCK;
                end
                else if (mode_reg == MODE_PATROL)
                begin
                    if (points != '0)
                    begin
                        patrol_idx_next = (idx_inc >= points) ? '0 : idx_inc[WP_IDX_W-1:0];
                        want_patrol = 1'b1;
                    end
                end
                else if (mode_reg == MODE_SERVICE)
                begin
                    if (svc_dwell_reg != 16'd0)
                    begin
                        dwell_left_next = svc_dwell_reg;
                        dwell_run_next = 1'b1;
                    end
                    else
                    begin
                        active_prio_next = '0;
                        if (svc_back_reg)
                        begin
                            mode_next = MODE_PATROL;
                            rest_deferred_next = 1'b0;
                            speed = SPEED_PATROL;
                            want_patrol = 1'b1;
                        end
                        else
                        begin
                            mode_next = MODE_STANDBY;
                        end
                    end
                end
                else if (mode_reg == MODE_RESTING)
                begin
                    mode_next = MODE_CHARGING;
                end
            end
            CMD_TICK:
            begin
                if (dwell_run_reg)
                begin
                    dwell_left_next = dwell_dec;
                    if (dwell_dec == 16'd0)
                    begin
                        dwell_run_next = 1'b0;
                        active_prio_next = '0;
                        if (svc_back_reg)
                        begin
                            mode_next = MODE_PATROL;
                            rest_deferred_next = 1'b0;
                            speed = SPEED_PATROL;
                            want_patrol = 1'b1;
                        end
                        else
                        begin
                            mode_next = MODE_STANDBY;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        // A patrol waypoint goes out only when waypoints exist; a stale index wraps first.
        if (want_patrol && points != '0)
        begin
            if ({1'b0, patrol_idx_next} >= points)
            begin
                patrol_idx_next = '0;
            end
            action = ACT_QUEUE;
            source = SRC_PATROL;
        end
    end

    always_comb
    begin
        result = '0;
        result.mode = mode_next;
        result.speed_set = speed;
        result.goal_action = action;
        result.cancel_nav = cancel;
        if (action != ACT_NONE)
        begin
            result.goal_source = source;
            if (source == SRC_PATROL)
            begin
                result.goal_waypoint = patrol_idx_next;
            end
            if (source == SRC_SERVICE)
            begin
                result.goal_x = svc_x_next;
                result.goal_y = svc_y_next;
                result.goal_heading = svc_heading_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_STANDBY;
            pause_mode_reg <= MODE_STANDBY;
            rest_deferred_reg <= 1'b0;
            halt_waiting_reg <= 1'b0;
            patrol_idx_reg <= '0;
            active_prio_reg <= '0;
            svc_x_reg <= '0;
            svc_y_reg <= '0;
            svc_heading_reg <= '0;
            svc_dwell_reg <= '0;
            svc_back_reg <= 1'b1;
            dwell_left_reg <= '0;
            dwell_run_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            pause_mode_reg <= pause_mode_next;
            rest_deferred_reg <= rest_deferred_next;
            halt_waiting_reg <= halt_waiting_next;
            patrol_idx_reg <= patrol_idx_next;
            active_prio_reg <= active_prio_next;
            svc_x_reg <= svc_x_next;
            svc_y_reg <= svc_y_next;
            svc_heading_reg <= svc_heading_next;
            svc_dwell_reg <= svc_dwell_next;
            svc_back_reg <= svc_back_next;
            dwell_left_reg <= dwell_left_next;
            dwell_run_reg <= dwell_run_next;
        end
    end

endmodule

### sv/robot_mission_mode_controller_top.sv
// Top level of the robot mission mode controller: channels, configuration and pipeline registers.
// An event beat waits in the event register until its result is registered into the result
// register. One event per cycle unless the result channel stalls; each register holds one beat.
// An event is taken while an earlier result still waits, as long as the result register frees up.
// Reset is asynchronous and active low; it empties both registers, restores the configuration
// defaults and puts the controller in standby.
module robot_mission_mode_controller_top #(
    parameter int unsigned MaxWaypoints = rmmc_pkg::MAX_WAYPOINTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    rmmc_event_if.sink                         event_ch,
    rmmc_result_if.source                      result_ch,
    input  logic                               cfg_we,
    input  logic [rmmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rmmc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rmmc_pkg::*;

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t res_reg;
    logic    res_valid_reg;
    result_t res_next;
    logic    advance;

    assign advance = item_valid_reg && (!res_valid_reg || result_ch.ready);
    assign event_ch.ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.battery_low_level <= BATT_LOW_RST;
            cfg_reg.battery_full_level <= BATT_FULL_RST;
            cfg_reg.patrol_point_count <= PATROL_CNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BATT_LOW: cfg_reg.battery_low_level <= cfg_data[LEVEL_W-1:0];
                REG_BATT_FULL: cfg_reg.battery_full_level <= cfg_data[LEVEL_W-1:0];
                REG_PATROL_CNT: cfg_reg.patrol_point_count <= cfg_data[WP_CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (event_ch.ready)
            begin
                item_valid_reg <= event_ch.valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (event_ch.valid && event_ch.ready)
        begin
            item_reg.cmd <= cmd_t'(event_ch.cmd);
            item_reg.req_priority <= event_ch.req_priority;
            item_reg.req_x <= event_ch.req_x;
            item_reg.req_y <= event_ch.req_y;
            item_reg.req_heading <= event_ch.req_heading;
            item_reg.req_dwell_ticks <= event_ch.req_dwell_ticks;
            item_reg.req_back_to_patrol <= event_ch.req_back_to_patrol;
            item_reg.req_halt_first <= event_ch.req_halt_first;
            item_reg.battery_level <= event_ch.battery_level;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    rmmc_core #(
        .MaxWaypoints(MaxWaypoints)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .cfg    (cfg_reg),
        .item   (item_reg),
        .result (res_next)
    );

    assign result_ch.valid = res_valid_reg;
    assign result_ch.mode = res_reg.mode;
    assign result_ch.speed_set = res_reg.speed_set;
    assign result_ch.goal_action = res_reg.goal_action;
    assign result_ch.goal_source = res_reg.goal_source;
    assign result_ch.goal_waypoint = res_reg.goal_waypoint;
    assign result_ch.goal_x = res_reg.goal_x;
    assign result_ch.goal_y = res_reg.goal_y;
    assign result_ch.goal_heading = res_reg.goal_heading;
    assign result_ch.cancel_nav = res_reg.cancel_nav;

endmodule

### sv/rmmc_checker.sv
// Port-level assertions for the mission mode controller and the bind that attaches them.
module rmmc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [2:0]  mode,
    input logic [1:0]  speed_set,
    input logic [1:0]  goal_action,
    input logic [1:0]  goal_source,
    input logic [3:0]  goal_waypoint,
    input logic [31:0] goal_x,
    input logic        cancel_nav
);
    import rmmc_pkg::*;

    // A stalled result beat keeps its mode and goal action.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(mode) && $stable(goal_action))
        else $error("Stalled result beat changed.");

    // Without a goal command the goal source, waypoint and x coordinate read zero.
    a_no_goal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && goal_action == ACT_NONE |->
        goal_source == SRC_PATROL && goal_waypoint == '0 && goal_x == '0)
        else $error("Goal fields set without a goal command.");

    // A cancel never comes with a new goal or speed.
    a_cancel_alone: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && cancel_nav |-> goal_action == ACT_NONE && speed_set == SPEED_KEEP)
        else $error("Cancel came with a goal or speed change.");

    // A service goal is only sent in service mode at service speed.
    a_service_goal: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && goal_action != ACT_NONE && goal_source == SRC_SERVICE |->
        mode == MODE_SERVICE && speed_set == SPEED_SERVICE)
        else $error("Service goal sent outside service mode.");

    // A dock goal is only sent while resting.
    a_dock_goal: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && goal_action != ACT_NONE && goal_source == SRC_DOCK |->
        mode == MODE_RESTING)
        else $error("Dock goal sent outside resting mode.");

endmodule

bind robot_mission_mode_controller_top rmmc_checker u_rmmc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (result_ch.valid),
    .res_ready     (result_ch.ready),
    .mode          (result_ch.mode),
    .speed_set     (result_ch.speed_set),
    .goal_action   (result_ch.goal_action),
    .goal_source   (result_ch.goal_source),
    .goal_waypoint (result_ch.goal_waypoint),
    .goal_x        (result_ch.goal_x),
    .cancel_nav    (result_ch.cancel_nav)
);
